### src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### src/bgs_pkg.sv
package bgs_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam int FRAC_W = 12;

  // pixel store geometry; the load and index ports are sized to match
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH = 64;

  typedef struct packed {
    logic locate;   // latch grid point, compute coordinates
    logic weigh;    // form corner weights
    logic issue;    // issue corner reads for one channel
    logic load;     // write the pending pixel
  } bgs_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic out_last;
    logic issue_last;
  } bgs_status_t;
endpackage

### src/bgs_ram.sv
module bgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### src/bgs_ctrl.sv
module bgs_ctrl import bgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        operation,
  input  bgs_status_t status,
  output logic        busy,
  output bgs_cmd_t    cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_LOC = 3'd1, S_WGT = 3'd2, S_ISSUE = 3'd3,
                         S_DRAIN = 3'd4;
  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_SAMPLE) begin
            cmd.locate = 1'b1;
            state_next = S_LOC;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_LOC: state_next = S_WGT;
      S_WGT: begin
        cmd.weigh = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.issue_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // wait for the last channel to leave the datapath
        if (status.out_valid && status.out_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

### src/bgs_datapath.sv
module bgs_datapath import bgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  bgs_cmd_t           cmd,
  input  logic               start,
  input  logic [3:0]         load_channel,
  input  logic [5:0]         load_row,
  input  logic [5:0]         load_col,
  input  logic signed [15:0] pixel_value,
  input  logic signed [15:0] grid_x,
  input  logic signed [15:0] grid_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output bgs_status_t        status,
  output logic [3:0]         channel_index,
  output logic signed [15:0] sampled_value,
  output logic               last
);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH);
  localparam int AW = CW + HW + WW;
  localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int CMAX = (MAX_CHANNELS > 16) ? 16 : MAX_CHANNELS;

  logic [6:0] reg_w, reg_h;
  logic [4:0] reg_n;
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w <= 7'd64;
      reg_h <= 7'd64;
      reg_n <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    reg_w <= cfg_data;
        REG_HEIGHT:   reg_h <= cfg_data;
        REG_CHANNELS: reg_n <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp sizes (effective)
  logic [10:0] w_eff, h_eff;
  logic [4:0]  n_eff;
  always_comb begin
    w_eff = (reg_w == 7'd0) ? 11'd1 : ({4'd0, reg_w} > 11'(MAX_WIDTH) ? 11'(MAX_WIDTH)
            : {4'd0, reg_w});
    h_eff = (reg_h == 7'd0) ? 11'd1 : ({4'd0, reg_h} > 11'(MAX_HEIGHT) ? 11'(MAX_HEIGHT)
            : {4'd0, reg_h});
    n_eff = (reg_n == 5'd0) ? 5'd1 : (reg_n > 5'(CMAX) ? 5'(CMAX) : reg_n);
  end

  // locate: q = (g+4096)*size - 4096, with 13 fraction bits
  logic signed [29:0] qx, qy;
  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      qx <= ($signed({{14{grid_x[15]}}, grid_x}) + 30'sd4096) * $signed({19'd0, w_eff})
            - 30'sd4096;
      qy <= ($signed({{14{grid_y[15]}}, grid_y}) + 30'sd4096) * $signed({19'd0, h_eff})
            - 30'sd4096;
    end
  end

  logic signed [16:0] x0, y0;
  logic [11:0] fx, fy;
  assign x0 = qx[29:13];
  assign y0 = qy[29:13];
  assign fx = qx[12:1];
  assign fy = qy[12:1];

  logic [12:0] wx0, wy0;
  assign wx0 = 13'd4096 - {1'b0, fx};
  assign wy0 = 13'd4096 - {1'b0, fy};

  logic [25:0] wnw, wne, wsw, wse;
  logic [3:0]  inb;  // nw, ne, sw, se in image
  logic        vx0, vx1, vy0, vy1;
  logic [WW-1:0] c0, c1;
  logic [HW-1:0] r0, r1;
  always_comb begin
    vx0 = (x0 >= 0) && (x0 < $signed({6'd0, w_eff}));
    vx1 = (x0 + 17'sd1 >= 0) && (x0 + 17'sd1 < $signed({6'd0, w_eff}));
    vy0 = (y0 >= 0) && (y0 < $signed({6'd0, h_eff}));
    vy1 = (y0 + 17'sd1 >= 0) && (y0 + 17'sd1 < $signed({6'd0, h_eff}));
  end
  logic [16:0] x1s, y1s;
  assign x1s = x0 + 17'sd1;
  assign y1s = y0 + 17'sd1;

  always_ff @(posedge clk) begin
    if (cmd.weigh) begin
      wnw <= 26'(wx0 * wy0);
      wne <= 26'({1'b0, fx} * wy0);
      wsw <= 26'(wx0 * {1'b0, fy});
      wse <= 26'({1'b0, fx} * {1'b0, fy});
      inb <= {vx0 & vy0, vx1 & vy0, vx0 & vy1, vx1 & vy1};
      c0 <= x0[WW-1:0];
      c1 <= x1s[WW-1:0];
      r0 <= y0[HW-1:0];
      r1 <= y1s[HW-1:0];
    end
  end

  // channel sequencer
  logic [4:0] ch;
  always_ff @(posedge clk) begin
    if (cmd.weigh) ch <= 5'd0;
    else if (cmd.issue) ch <= ch + 5'd1;
  end
  logic issue_last;
  assign issue_last = (ch + 5'd1 == n_eff);

  // four banked stores, one per corner, each holding every pixel
  logic [AW-1:0] waddr;
  logic          we;
  assign we = cmd.load && start && ({28'd0, load_channel} < 32'(MAX_CHANNELS))
              && ({26'd0, load_row} < 32'(MAX_HEIGHT)) && ({26'd0, load_col} < 32'(MAX_WIDTH));
  assign waddr = {load_channel[CW-1:0], load_row[HW-1:0], load_col[WW-1:0]};

  logic [CW-1:0] chs;
  assign chs = ch[CW-1:0];
  logic [AW-1:0] ra [4];
  assign ra[0] = {chs, r0, c0};
  assign ra[1] = {chs, r0, c1};
  assign ra[2] = {chs, r1, c0};
  assign ra[3] = {chs, r1, c1};
  logic [15:0] rd [4];
  for (genvar k = 0; k < 4; k++) begin : g_bank
    bgs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
      .clk(clk), .we(we), .waddr(waddr), .wdata(pixel_value),
      .raddr(ra[k]), .rdata(rd[k])
    );
  end

  // stage 1: read data valid; stage 2: products; stage 3: sum and saturate
  logic       v1, v2, v3;
  logic       l1, l2, l3;
  logic [3:0] c1i, c2i, c3i;
  logic signed [42:0] p [4];
  logic signed [15:0] res;
  logic signed [44:0] acc;
  logic [25:0] wsel [4];
  assign wsel[0] = wnw;
  assign wsel[1] = wne;
  assign wsel[2] = wsw;
  assign wsel[3] = wse;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
    l1 <= issue_last;
    c1i <= ch[3:0];
    l2 <= l1;
    c2i <= c1i;
    for (int k = 0; k < 4; k++) begin
      p[k] <= inb[3-k] ? $signed(rd[k]) * $signed({1'b0, wsel[k]}) : 43'sd0;
    end
    l3 <= l2;
    c3i <= c2i;
    if ($signed(acc[44:24]) > 21'sd32767) res <= 16'sh7fff;
    else if ($signed(acc[44:24]) < -21'sd32768) res <= 16'sh8000;
    else res <= acc[39:24];
  end
  assign acc = 45'(p[0]) + 45'(p[1]) + 45'(p[2]) + 45'(p[3]);

  assign status.out_valid = v3;
  assign status.out_last = l3;
  assign status.issue_last = issue_last;
  assign channel_index = c3i;
  assign sampled_value = res;
  assign last = v3 & l3;
endmodule

### src/bilinear_grid_sampler_core.sv
// Bilinear grid sampler with zero padding.
// Command channel: an item is taken when start is high and busy is low. With
// operation = 0 the item writes pixel_value at (load_channel, load_row,
// load_col) in the same cycle; busy never rises and no result follows.
// With operation = 1 the item samples the image at (grid_x, grid_y), Q3.12.
// Results: one per channel, shown for one cycle with done high; channel_index
// counts up from 0 and last marks the final channel. The receiver cannot stall.
// A sample item steps through locate, weigh, issue and drain; its results
// then follow one per cycle, and busy stays high until the last is shown.
// The channel sequencer issues one channel per cycle to four corner banks of
// the pixel store, each a full copy, so all four corners read at once.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Reset restores width 64, height 64, one channel; the pixel store is not
// cleared and every pixel must be loaded before it is sampled.
module bilinear_grid_sampler_core import bgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [3:0]         load_channel,
  input  logic [5:0]         load_row,
  input  logic [5:0]         load_col,
  input  logic signed [15:0] pixel_value,
  input  logic signed [15:0] grid_x,
  input  logic signed [15:0] grid_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               done,
  output logic [3:0]         channel_index,
  output logic signed [15:0] sampled_value,
  output logic               last
);
`include "assert_macros.svh"
  bgs_cmd_t    cmd;
  bgs_status_t status;

  // controller: sequence locate, weigh, and per-channel issue
  bgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .status(status), .busy(busy), .cmd(cmd)
  );

  // datapath: registers, coordinate math, corner banks, blend pipeline
  bgs_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .start(start),
    .load_channel(load_channel), .load_row(load_row), .load_col(load_col),
    .pixel_value(pixel_value), .grid_x(grid_x), .grid_y(grid_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .channel_index(channel_index),
    .sampled_value(sampled_value), .last(last)
  );

  assign done = status.out_valid;

  `ASSERT_NEVER(a_done_idle, clk, rst, done && !busy, "result while idle")
  `ASSERT_IMPL(a_last_idle, clk, rst, done && last |=> !busy, "busy after last")
  `ASSERT_NEVER(a_issue_load, clk, rst, cmd.issue && cmd.load, "load during sample")
endmodule

### test/bilinear_grid_sampler_core_tb.sv
module bilinear_grid_sampler_core_tb;
  import bgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 16;
  localparam int NROW = 64;
  localparam int NCOL = 64;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [3:0]         ch;
    logic signed [15:0] value;
    logic               lst;
  } blend_t;

  // Tracks the pixel image and sampler settings; predicts blended results.
  class blend_scoreboard;
    logic signed [15:0] pixels [NCH*NROW*NCOL];
    bit                 loaded [NCH*NROW*NCOL];
    int                 img_w = 64, img_h = 64, chans = 1;
    blend_t             pending [$];
    int                 errors = 0;

    function int clamp(int v, int hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] data);
      if (idx == REG_WIDTH) img_w = clamp(data, NCOL);
      else if (idx == REG_HEIGHT) img_h = clamp(data, NROW);
      else if (idx == REG_CHANNELS) chans = clamp(data[4:0], NCH);
    endfunction

    function longint pix(int c, longint r, longint k);
      if (r < 0 || k < 0 || r >= img_h || k >= img_w) return 0;
      return pixels[(c*NROW + int'(r))*NCOL + int'(k)];
    endfunction

    // Note an accepted item: store a pixel, or queue one result per channel.
    function void note_item(logic op, logic [3:0] lc, logic [5:0] lr, logic [5:0] lk,
                            logic signed [15:0] pv, logic signed [15:0] gx,
                            logic signed [15:0] gy);
      longint xq, yq, x0, y0, fx, fy, acc, v;
      blend_t e;
      if (op == OP_LOAD) begin
        pixels[(int'(lc)*NROW + int'(lr))*NCOL + int'(lk)] = pv;
        loaded[(int'(lc)*NROW + int'(lr))*NCOL + int'(lk)] = 1'b1;
        return;
      end
      xq = (longint'(gx) + 4096) * img_w - 4096;
      yq = (longint'(gy) + 4096) * img_h - 4096;
      x0 = xq >>> 13;
      y0 = yq >>> 13;
      fx = (xq - x0 * 8192) >>> 1;
      fy = (yq - y0 * 8192) >>> 1;
      for (int c = 0; c < chans; c++) begin
        acc = pix(c, y0, x0) * (4096 - fx) * (4096 - fy)
            + pix(c, y0, x0 + 1) * fx * (4096 - fy)
            + pix(c, y0 + 1, x0) * (4096 - fx) * fy
            + pix(c, y0 + 1, x0 + 1) * fx * fy;
        v = acc >>> 24;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        e.ch = c[3:0];
        e.value = v[15:0];
        e.lst = (c + 1 == chans);
        pending.push_back(e);
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check(logic [3:0] ch, logic signed [15:0] value, logic lst);
      blend_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result ch=%0d value=%0d", ch, value));
        return;
      end
      e = pending.pop_front();
      if (ch !== e.ch) report($sformatf("channel_index %0d, want %0d", ch, e.ch));
      if (value !== e.value)
        report($sformatf("sampled_value %0d, want %0d (ch %0d)", value, e.value, e.ch));
      if (lst !== e.lst) report($sformatf("last %0b, want %0b (ch %0d)", lst, e.lst, e.ch));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = OP_LOAD;
  logic [3:0] load_channel = '0;
  logic [5:0] load_row = '0;
  logic [5:0] load_col = '0;
  logic signed [15:0] pixel_value = '0;
  logic signed [15:0] grid_x = '0;
  logic signed [15:0] grid_y = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [6:0] cfg_data = '0;
  logic done;
  logic [3:0] channel_index;
  logic signed [15:0] sampled_value;
  logic last;

  blend_scoreboard sb = new();
  bit steady = 1'b0;   // set during the stretch with no gaps
  int stall_cycles = 0;

  bilinear_grid_sampler_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .load_channel(load_channel), .load_row(load_row), .load_col(load_col),
    .pixel_value(pixel_value), .grid_x(grid_x), .grid_y(grid_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .channel_index(channel_index), .sampled_value(sampled_value),
    .last(last)
  );

  always #2 clk = ~clk;

  // Check every result in the cycle it is shown; count cycles with no progress.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check(channel_index, sampled_value, last);
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send(logic op, logic [3:0] lc, logic [5:0] lr, logic [5:0] lk,
                      logic signed [15:0] pv, logic signed [15:0] gx,
                      logic signed [15:0] gy);
    if (!steady && $urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    load_channel <= lc;
    load_row <= lr;
    load_col <= lk;
    pixel_value <= pv;
    grid_x <= gx;
    grid_y <= gy;
    do @(posedge clk); while (busy);
    sb.note_item(op, lc, lr, lk, pv, gx, gy);
  endtask

  task automatic sample(logic signed [15:0] gx, logic signed [15:0] gy);
    send(OP_SAMPLE, 4'($urandom), 6'($urandom), 6'($urandom), 16'($urandom), gx, gy);
  endtask

  task automatic load_random();
    send(OP_LOAD, 4'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  // Hold off until every expected result is out, then let the pipe drain.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Write one register, then return the enable low.
  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Change the image shape, then load every pixel a sample could read.
  task automatic set_shape(logic [6:0] w, logic [6:0] h, logic [6:0] n);
    logic signed [15:0] pv;
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CHANNELS, n);
    for (int c = 0; c < sb.chans; c++)
      for (int r = 0; r < sb.img_h; r++)
        for (int k = 0; k < sb.img_w; k++)
          if (!sb.loaded[(c*NROW + r)*NCOL + k]) begin
            case ($urandom_range(7))
              0: pv = 16'sh7fff;
              1: pv = 16'sh8000;
              default: pv = 16'($urandom);
            endcase
            send(OP_LOAD, c[3:0], r[5:0], k[5:0], pv, 16'($urandom), 16'($urandom));
          end
  endtask

  // Mostly points near the image, some anywhere in the Q3.12 range.
  task automatic random_sample();
    if ($urandom_range(3) == 0) sample(16'($urandom), 16'($urandom));
    else sample(16'($urandom_range(8800) - 4400), 16'($urandom_range(8800) - 4400));
  endtask

  task automatic random_phase(int items);
    set_shape(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
    for (int i = 0; i < items; i++)
      if ($urandom_range(9) < 7) random_sample();
      else load_random();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small image and coordinate extremes.
    set_shape(7'd6, 7'd6, 7'd1);
    sample(16'sh8000, 16'sh8000);
    sample(16'sh7fff, 16'sh7fff);
    sample(16'sh8000, 16'sh7fff);
    sample(16'sh0000, 16'sh0000);
    sample(-16'sd4096, -16'sd4096);
    sample(16'sd4096, 16'sd4096);
    sample(16'sd4095, -16'sd4097);
    sample(16'sd64, -16'sd64);
    sample(16'sd4032, 16'sd0);

    // Out-of-range settings saturate: zero gives a 1x1 image, large gives max.
    set_shape(7'd0, 7'd0, 7'd31);
    sample(16'sh0000, 16'sh0000);
    sample(-16'sd4096, 16'sd4096);
    sample(16'sd2048, -16'sd2048);
    sample(16'sh7fff, 16'sh8000);
    drain();
    write_reg(REG_WIDTH, 7'd127);
    write_reg(REG_HEIGHT, 7'd2);
    write_reg(REG_CHANNELS, 7'd0);
    set_shape(7'd127, 7'd1, 7'd0);
    sample(16'sd100, 16'sd1000);
    sample(-16'sd4000, 16'sd2000);
    sample(16'sd4095, 16'sd4095);
    sample(16'sh7fff, 16'sh0000);
    sample(16'sh8000, 16'sh0000);
    drain();

    // Stretch with no gaps, then random phases over varied shapes.
    steady = 1'b1;
    random_phase(22);
    steady = 1'b0;
    for (int p = 0; p < 4; p++) random_phase(22);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
